[rtl/core/twd_pkg.sv]
package twd_pkg;

  localparam int MAX_SIZE  = 1024;
  localparam int IDX_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int ALPHA_W   = 17;
  localparam int WEIGHT_W  = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 17;

  localparam int M_W       = 10;
  localparam int H2_W      = 26;
  localparam int DIST_W    = 27;
  localparam int DIV_STEPS = 28;
  localparam int P_W       = 29;
  localparam int THETA_W   = 30;
  localparam int T2_W      = 32;
  localparam int TERM_W    = 32;
  localparam int SUM_W     = 34;
  localparam int WQ29_W    = 30;

  localparam int NUM_TERMS  = 11;
  localparam int SER_STAGES = NUM_TERMS - 1;

  // per-lane latency: taper select, distance, divider, theta, square, first term,
  // five stages for each further series term, clamp
  localparam int LANE_LAT = 2 + DIV_STEPS + 5 + 2 + 5 * SER_STAGES + 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPER_FRACTION = 1'd1;

  localparam logic [SIZE_W-1:0]  RST_SIZE  = 11'd256;
  localparam logic [ALPHA_W-1:0] RST_ALPHA = 17'd32768;
  localparam logic [SIZE_W-1:0]  SIZE_CAP  = SIZE_W'(MAX_SIZE);
  localparam logic [ALPHA_W-1:0] ONE_Q16   = 17'd65536;

  // floor(x / 125) = (x * DIV125_MAG) >> 30 for x below 2^24
  localparam logic [23:0] DIV125_MAG = 24'd8589935;

  localparam logic [63:0] TWO_35 = 64'd34359738368;

  // series denominators (2i-1)(2i) from the second term on, and their
  // reciprocals scaled by 2^35, rounded up
  localparam logic [8:0] TAY_DEN [SER_STAGES] = '{
    9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380, 9'd462
  };
  localparam logic [31:0] TAY_MAG [SER_STAGES] = '{
    32'((TWO_35 + 64'd11) / 64'd12),
    32'((TWO_35 + 64'd29) / 64'd30),
    32'((TWO_35 + 64'd55) / 64'd56),
    32'((TWO_35 + 64'd89) / 64'd90),
    32'((TWO_35 + 64'd131) / 64'd132),
    32'((TWO_35 + 64'd181) / 64'd182),
    32'((TWO_35 + 64'd239) / 64'd240),
    32'((TWO_35 + 64'd305) / 64'd306),
    32'((TWO_35 + 64'd379) / 64'd380),
    32'((TWO_35 + 64'd461) / 64'd462)
  };

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
  } twd_in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                index_error;
  } twd_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] n_eff;
    logic [M_W-1:0]    m;
    logic [H2_W-1:0]   h2;
    logic [M_W-1:0]    b1;
    logic [M_W-1:0]    b2;
    logic              flat;
  } twd_geom_t;

  function automatic twd_geom_t calc_geom(input logic [SIZE_W-1:0] size,
                                          input logic [ALPHA_W-1:0] alpha);
    logic [SIZE_W-1:0]  n_eff;
    logic [ALPHA_W-1:0] a_eff;
    logic [26:0]        prod;
    logic [26:0]        lo;
    logic [26:0]        hi;
    twd_geom_t          g;
    n_eff   = (size > SIZE_CAP) ? SIZE_CAP : size;
    a_eff   = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
    g.n_eff = n_eff;
    g.m     = M_W'(n_eff - 11'd1);
    prod    = 27'(a_eff) * 27'(g.m);
    g.h2    = prod[H2_W-1:0];
    lo      = prod + 27'd65536;
    g.b1    = lo[26:17];
    hi      = {g.m, 17'd0} - prod + 27'd65536;
    g.b2    = hi[26:17];
    g.flat  = (a_eff == '0) || (n_eff <= 11'd1);
    return g;
  endfunction

endpackage

[rtl/core/twd_lane.sv]
module twd_lane (
  input  logic                          clk,
  input  logic [twd_pkg::IDX_W-1:0]     idx,
  input  twd_pkg::twd_geom_t            geom,
  output logic [twd_pkg::WQ29_W-1:0]    weight_q29
);

  localparam int NT = twd_pkg::SER_STAGES;
  localparam int DS = twd_pkg::DIV_STEPS;

  // taper select
  logic [twd_pkg::M_W-1:0] k_a_r, k_a_nxt;
  logic                    one_a_r, one_a_nxt;
  logic                    le_b1, le_b2;

  always_comb begin
    le_b1     = idx <= geom.b1;
    le_b2     = idx <= geom.b2;
    one_a_nxt = geom.flat | (!le_b1 & le_b2);
    k_a_nxt   = le_b1 ? idx : twd_pkg::M_W'(geom.m - idx);
  end

  always_ff @(posedge clk) begin
    k_a_r   <= k_a_nxt;
    one_a_r <= one_a_nxt;
  end

  // distance from the taper centre, capped when it reaches the half width
  logic [twd_pkg::DIST_W-1:0] target, h2x, span;
  logic                       cap_nxt;
  logic [DS-1:0]              numlo;

  logic [twd_pkg::H2_W-1:0] rem_r [DS+1];
  logic [DS-1:0]            quo_r [DS+1];
  logic                     cap_r [DS+1];
  logic                     one_d_r [DS+1];

  always_comb begin
    target  = {k_a_r, 17'd0};
    h2x     = {1'b0, geom.h2};
    span    = (target > h2x) ? target - h2x : h2x - target;
    cap_nxt = span >= h2x;
    numlo   = {3'd0, geom.h2[twd_pkg::H2_W-1:1]};
  end

  always_ff @(posedge clk) begin
    rem_r[0]   <= cap_nxt ? '0 : span[twd_pkg::H2_W-1:0];
    quo_r[0]   <= '0;
    cap_r[0]   <= cap_nxt;
    one_d_r[0] <= one_a_r;
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [twd_pkg::DIST_W-1:0] trial;
    logic                       ge;
    logic [twd_pkg::H2_W-1:0]   rem_nxt;

    always_comb begin
      trial   = {rem_r[j], numlo[DS-1-j]};
      ge      = trial >= h2x;
      rem_nxt = ge ? twd_pkg::H2_W'(trial - h2x) : trial[twd_pkg::H2_W-1:0];
    end

    always_ff @(posedge clk) begin
      rem_r[j+1]   <= rem_nxt;
      quo_r[j+1]   <= {quo_r[j][DS-2:0], ge};
      cap_r[j+1]   <= cap_r[j];
      one_d_r[j+1] <= one_d_r[j];
    end
  end

  // theta = 3p + floor((283p + 1000) / 2000), split into two base-2^16 digits
  logic [twd_pkg::P_W-1:0] p_val;
  logic [36:0]             tha_r;
  logic [twd_pkg::P_W-1:0] p_ta_r, p_tb_r, p_tc_r, p_td_r;
  logic                    one_ta_r, one_tb_r, one_tc_r, one_td_r;
  logic [32:0]             bq;
  logic [40:0]             hm125_r;
  logic [16:0]             bh_r;
  logic [15:0]             bl_r;
  logic [10:0]             qh125, qh125_r, qh125_d_r;
  logic [16:0]             rh_full;
  logic [22:0]             x125_r;
  logic [46:0]             lm125_r;
  logic [15:0]             ql125;
  logic [30:0]             theta_sum;
  logic [twd_pkg::THETA_W-1:0] theta_r;
  logic                        one_th_r;

  always_comb begin
    p_val     = cap_r[DS] ? 29'h1000_0000 : {1'b0, quo_r[DS]};
    bq        = tha_r[36:4];
    qh125     = hm125_r[40:30];
    rh_full   = bh_r - 17'(qh125) * 17'd125;
    ql125     = lm125_r[45:30];
    theta_sum = 31'({p_td_r, 1'b0}) + 31'(p_td_r) + 31'({qh125_d_r, ql125});
  end

  always_ff @(posedge clk) begin
    tha_r     <= 37'(p_val) * 37'd283 + 37'd1000;
    p_ta_r    <= p_val;
    one_ta_r  <= one_d_r[DS];

    hm125_r   <= 41'(bq[32:16]) * 41'(twd_pkg::DIV125_MAG);
    bh_r      <= bq[32:16];
    bl_r      <= bq[15:0];
    p_tb_r    <= p_ta_r;
    one_tb_r  <= one_ta_r;

    x125_r    <= {rh_full[6:0], bl_r};
    qh125_r   <= qh125;
    p_tc_r    <= p_tb_r;
    one_tc_r  <= one_tb_r;

    lm125_r   <= 47'(x125_r) * 47'(twd_pkg::DIV125_MAG);
    qh125_d_r <= qh125_r;
    p_td_r    <= p_tc_r;
    one_td_r  <= one_tc_r;

    theta_r   <= theta_sum[twd_pkg::THETA_W-1:0];
    one_th_r  <= one_td_r;
  end

  // square, then first series term
  logic [59:0] sq_r;
  logic        one_sq_r;
  logic [60:0] sq_rnd;
  logic [twd_pkg::T2_W-1:0] t2_first;
  logic [32:0]              term1_sum;

  logic [twd_pkg::TERM_W-1:0]      tm_term_r [NT+1];
  logic signed [twd_pkg::SUM_W-1:0] tm_sum_r [NT+1];
  logic [twd_pkg::T2_W-1:0]        tm_t2_r [NT+1];
  logic                            tm_one_r [NT+1];

  always_comb begin
    sq_rnd    = 61'(sq_r) + 61'd134217728;
    t2_first  = sq_rnd[59:28];
    term1_sum = 33'(t2_first) + 33'd1;
  end

  always_ff @(posedge clk) begin
    sq_r         <= 60'(theta_r) * 60'(theta_r);
    one_sq_r     <= one_th_r;
    tm_t2_r[0]   <= t2_first;
    tm_term_r[0] <= term1_sum[32:1];
    tm_sum_r[0]  <= 34'sd268435456 - $signed({2'b00, term1_sum[32:1]});
    tm_one_r[0]  <= one_sq_r;
  end

  // remaining series terms: multiply, round, divide by the constant in two digits
  for (genvar g = 0; g < NT; g++) begin : g_term
    localparam bit SUB = (g % 2) == 1;

    logic [63:0]                      pa_r;
    logic signed [twd_pkg::SUM_W-1:0] sa_r, sb_r, sc_r, sd_r;
    logic [twd_pkg::T2_W-1:0]         ta_r, tb_r, tc_r, td_r;
    logic                             oa_r, ob_r, oc_r, od_r;
    logic [63:0]                      pr;
    logic [34:0]                      yb;
    logic [49:0]                      hmb_r;
    logic [17:0]                      yhb_r;
    logic [16:0]                      ylb_r;
    logic [14:0]                      qh;
    logic [17:0]                      rh;
    logic [25:0]                      xc_r;
    logic [14:0]                      qhc_r, qhd_r;
    logic [57:0]                      lmd_r;
    logic [twd_pkg::TERM_W-1:0]       term;
    logic signed [twd_pkg::SUM_W-1:0] sterm;

    always_comb begin
      pr    = pa_r + 64'd134217728;
      yb    = pr[62:28] + 35'(twd_pkg::TAY_DEN[g][8:1]);
      qh    = hmb_r[49:35];
      rh    = yhb_r - 18'(qh) * 18'(twd_pkg::TAY_DEN[g]);
      term  = {qhd_r, lmd_r[51:35]};
      sterm = $signed({2'b00, term});
    end

    always_ff @(posedge clk) begin
      pa_r  <= 64'(tm_term_r[g]) * 64'(tm_t2_r[g]);
      sa_r  <= tm_sum_r[g];
      ta_r  <= tm_t2_r[g];
      oa_r  <= tm_one_r[g];

      hmb_r <= 50'(yb[34:17]) * 50'(twd_pkg::TAY_MAG[g]);
      yhb_r <= yb[34:17];
      ylb_r <= yb[16:0];
      sb_r  <= sa_r;
      tb_r  <= ta_r;
      ob_r  <= oa_r;

      xc_r  <= {rh[8:0], ylb_r};
      qhc_r <= qh;
      sc_r  <= sb_r;
      tc_r  <= tb_r;
      oc_r  <= ob_r;

      lmd_r <= 58'(xc_r) * 58'(twd_pkg::TAY_MAG[g]);
      qhd_r <= qhc_r;
      sd_r  <= sc_r;
      td_r  <= tc_r;
      od_r  <= oc_r;

      tm_term_r[g+1] <= term;
      tm_sum_r[g+1]  <= SUB ? sd_r - sterm : sd_r + sterm;
      tm_t2_r[g+1]   <= td_r;
      tm_one_r[g+1]  <= od_r;
    end
  end

  // (1 + cos) / 2 in Q29, clamped; flat part forced to one
  logic signed [34:0]          s_fin;
  logic [twd_pkg::WQ29_W-1:0]  w_nxt, w_r;

  always_comb begin
    s_fin = 35'sd268435456 + 35'(tm_sum_r[NT]);
    if (tm_one_r[NT] || s_fin > 35'sd536870912) begin
      w_nxt = 30'h2000_0000;
    end else if (s_fin < 35'sd0) begin
      w_nxt = '0;
    end else begin
      w_nxt = s_fin[twd_pkg::WQ29_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  assign weight_q29 = w_r;

endmodule

[rtl/core/tukey_window_2d_weight.sv]
// Tukey window weight for a square window: returns w(column) * w(row) in Q1.16.
// One beat is taken every clock (busy never rises) and each result leaves on
// out_strobe for a single cycle; the receiver cannot stall. The pipeline holds
// the 28-stage divider that normalises the taper position and the eleven-term
// cosine series, two stages for the square and first term and five stages for
// each term after it.
// Indices at or beyond the window size return weight 0 with index_error set.
// Write the registers only while no beat is in flight; a write applies to
// beats started from the next cycle on.
module tukey_window_2d_weight (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  twd_pkg::twd_in_t                 in_data,
  output logic                             out_strobe,
  output twd_pkg::twd_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [twd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [twd_pkg::CFG_W-1:0]        cfg_data
);

  localparam int LAT = twd_pkg::LANE_LAT;

  logic [twd_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [twd_pkg::ALPHA_W-1:0] alpha_r, alpha_nxt;
  twd_pkg::twd_geom_t          geom_r, geom_nxt;

  always_comb begin
    size_nxt  = size_r;
    alpha_nxt = alpha_r;
    if (cfg_we) begin
      unique case (cfg_index)
        twd_pkg::REG_WINDOW_SIZE:    size_nxt  = cfg_data[twd_pkg::SIZE_W-1:0];
        twd_pkg::REG_TAPER_FRACTION: alpha_nxt = cfg_data;
      endcase
    end
    geom_nxt = twd_pkg::calc_geom(size_nxt, alpha_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= twd_pkg::RST_SIZE;
      alpha_r <= twd_pkg::RST_ALPHA;
      geom_r  <= twd_pkg::calc_geom(twd_pkg::RST_SIZE, twd_pkg::RST_ALPHA);
    end else begin
      size_r  <= size_nxt;
      alpha_r <= alpha_nxt;
      geom_r  <= geom_nxt;
    end
  end

  assign busy = 1'b0;

  logic                       accept;
  logic                       err_nxt;
  logic [twd_pkg::IDX_W-1:0]  col_r, row_r;
  logic                       vld_r [LAT+1];
  logic                       err_r [LAT+1];

  always_comb begin
    accept  = start & !busy;
    err_nxt = ({1'b0, in_data.column} >= geom_r.n_eff) ||
              ({1'b0, in_data.row} >= geom_r.n_eff);
  end

  always_ff @(posedge clk) begin
    col_r    <= in_data.column;
    row_r    <= in_data.row;
    err_r[0] <= err_nxt;
    for (int i = 0; i < LAT; i++) begin
      err_r[i+1] <= err_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 0; i < LAT; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  logic [twd_pkg::WQ29_W-1:0] wx, wy;

  twd_lane u_col (
    .clk        (clk),
    .idx        (col_r),
    .geom       (geom_r),
    .weight_q29 (wx)
  );

  twd_lane u_row (
    .clk        (clk),
    .idx        (row_r),
    .geom       (geom_r),
    .weight_q29 (wy)
  );

  logic [59:0] prod_r;
  logic        vld_p_r, err_p_r;
  logic [60:0] prod_rnd;
  logic [18:0] w_full;
  logic [twd_pkg::WEIGHT_W-1:0] w_nxt;
  twd_pkg::twd_out_t out_r, out_nxt;
  logic              out_vld_r;

  always_comb begin
    prod_rnd = 61'(prod_r) + 61'h200_0000_0000;
    w_full   = prod_rnd[60:42];
    w_nxt    = (w_full > 19'(twd_pkg::ONE_Q16)) ? twd_pkg::ONE_Q16 : w_full[16:0];
    out_nxt.weight      = err_p_r ? '0 : w_nxt;
    out_nxt.index_error = err_p_r;
  end

  always_ff @(posedge clk) begin
    prod_r  <= 60'(wx) * 60'(wy);
    err_p_r <= err_r[LAT];
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_p_r   <= vld_r[LAT];
      out_vld_r <= vld_p_r;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

[tb/twd_weight_checker.sv]
module twd_weight_checker
  import twd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  twd_in_t              in_data,
  input  logic                 out_strobe,
  input  twd_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] Q28_ONE = 64'd268435456;
  localparam logic [63:0] Q29_ONE = 64'd536870912;

  logic [SIZE_W-1:0]  window_size;
  logic [ALPHA_W-1:0] taper_fraction;
  twd_out_t           expected_weights[$];

  function automatic longint signed cosine_q28(input logic [63:0] theta);
    logic [63:0]    t2;
    logic [63:0]    term;
    logic [63:0]    den;
    longint signed  acc;
    t2   = (theta * theta + (Q28_ONE >> 1)) >> 28;
    term = Q28_ONE;
    acc  = longint'(Q28_ONE);
    for (int i = 1; i <= 11; i++) begin
      den  = 64'((2 * i - 1) * (2 * i));
      term = (term * t2 + (Q28_ONE >> 1)) >> 28;
      term = (term + den / 2) / den;
      if (i % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return acc;
  endfunction

  // 1-D taper weight in Q29
  function automatic logic [63:0] taper_q29(input logic [63:0] idx, input logic [63:0] m,
                                             input logic [63:0] alpha);
    logic [63:0]   h2;
    logic [63:0]   lo_bound;
    logic [63:0]   hi_bound;
    logic [63:0]   k;
    logic [63:0]   pos;
    logic [63:0]   span;
    logic [63:0]   frac;
    logic [63:0]   theta;
    longint signed s;
    if (alpha == 0 || m == 0) return Q29_ONE;
    h2       = alpha * m;
    lo_bound = (h2 + 64'd65536) >> 17;
    hi_bound = (m * 64'd131072 - h2 + 64'd65536) >> 17;
    if (idx <= lo_bound) k = idx;
    else if (idx <= hi_bound) return Q29_ONE;
    else k = m - idx;
    pos  = k * 64'd131072;
    span = (pos > h2) ? pos - h2 : h2 - pos;
    frac = ((span << 28) + h2 / 2) / h2;
    if (frac > Q28_ONE) frac = Q28_ONE;
    theta = (frac * 64'd31415 + 64'd5000) / 64'd10000;
    s = longint'(Q28_ONE) + cosine_q28(theta);
    if (s < 0) s = 0;
    if (s > longint'(Q29_ONE)) s = longint'(Q29_ONE);
    return 64'(s);
  endfunction

  function automatic twd_out_t window_weight(input twd_in_t px, input logic [SIZE_W-1:0] size,
                                             input logic [ALPHA_W-1:0] alpha);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] wx;
    logic [63:0] wy;
    logic [63:0] w;
    twd_out_t    r;
    n = (size > 11'd1024) ? 64'd1024 : 64'(size);
    a = (alpha > ONE_Q16) ? 64'd65536 : 64'(alpha);
    if (64'(px.column) >= n || 64'(px.row) >= n) begin
      r.weight      = '0;
      r.index_error = 1'b1;
      return r;
    end
    wx = taper_q29(64'(px.column), n - 1, a);
    wy = taper_q29(64'(px.row), n - 1, a);
    w  = (wx * wy + (64'd1 << 41)) >> 42;
    if (w > 64'd65536) w = 64'd65536;
    r.weight      = w[WEIGHT_W-1:0];
    r.index_error = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    twd_out_t want;
    if (!rst_n) begin
      window_size    <= RST_SIZE;
      taper_fraction <= RST_ALPHA;
      expected_weights.delete();
      pending = 0;
    end else begin
      if (out_strobe) begin
        if (expected_weights.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_weights.pop_front();
          if (out_data.weight !== want.weight)
            report_mismatch($sformatf("weight %0d, expected %0d", out_data.weight,
                                      want.weight));
          if (out_data.index_error !== want.index_error)
            report_mismatch($sformatf("index_error %b, expected %b",
                                      out_data.index_error, want.index_error));
        end
      end
      if (start && !busy)
        expected_weights.push_back(window_weight(in_data, window_size, taper_fraction));
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW_SIZE) window_size <= cfg_data[SIZE_W-1:0];
        else if (cfg_index == REG_TAPER_FRACTION) taper_fraction <= cfg_data[ALPHA_W-1:0];
      end
      pending = expected_weights.size();
    end
  end
endmodule

[tb/tb_tukey_window_2d_weight.sv]
module tb_tukey_window_2d_weight;
  import twd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_SETTINGS = 10;
  localparam int BEATS_PER_SETTING = 45;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  twd_in_t              in_data = '0;
  logic                 out_strobe;
  twd_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_SIZE;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   gap_pct = 0;
  int                   n_now = 256;

  logic [SIZE_W-1:0]  sizes  [NUM_SETTINGS] = '{11'd2, 11'd1024, 11'd2047, 11'd1, 11'd0,
                                                 11'd1000, 11'd37, 11'd512, 11'd1025, 11'd3};
  logic [ALPHA_W-1:0] alphas [NUM_SETTINGS] = '{17'd65536, 17'd0, 17'd131071, 17'd32768,
                                                 17'd100, 17'd65536, 17'd1, 17'd20000,
                                                 17'd65537, 17'd45000};

  always #6 clk = ~clk;

  tukey_window_2d_weight dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  twd_weight_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_tukey_window_2d_weight failed");
      $finish;
    end
  end

  // one beat; idle each cycle with the gap odds first when idling is on
  task automatic send_beat(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(99) < gap_pct) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= '{column: col, row: row};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [SIZE_W-1:0] size, input logic [ALPHA_W-1:0] alpha);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data  <= CFG_W'(size);
    @(negedge clk);
    cfg_index <= REG_TAPER_FRACTION;
    cfg_data  <= CFG_W'(alpha);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_now = (size > 11'd1024) ? 1024 : int'(size);
  endtask

  task automatic random_beat;
    if (n_now > 0 && $urandom_range(99) < 80)
      send_beat(IDX_W'($urandom_range(n_now - 1)), IDX_W'($urandom_range(n_now - 1)));
    else
      send_beat(IDX_W'($urandom), IDX_W'($urandom));
  endtask

  initial begin
    int beat_no;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: corners, taper edges, out-of-window and bit patterns
    send_beat(10'd0, 10'd0);
    send_beat(10'd255, 10'd255);
    send_beat(10'd128, 10'd128);
    send_beat(10'd64, 10'd0);
    send_beat(10'd63, 10'd64);
    send_beat(10'd191, 10'd192);
    send_beat(10'd256, 10'd0);
    send_beat(10'd0, 10'd256);
    send_beat(10'd1023, 10'd1023);
    send_beat(10'h2AA, 10'h155);
    send_beat(10'h155, 10'h2AA);
    drain();
    set_window(11'd5, 17'd65536);
    for (int i = 0; i < 6; i++) send_beat(IDX_W'(i), IDX_W'(5 - i));
    drain();

    beat_no = 0;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      set_window(sizes[s], alphas[s]);
      for (int i = 0; i < BEATS_PER_SETTING; i++) begin
        gap_pct = (beat_no < 150) ? 7 : (beat_no < 300) ? 87 : 0;
        random_beat();
        beat_no++;
      end
      drain();
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_tukey_window_2d_weight passed");
    end else begin
      $display("tb_tukey_window_2d_weight failed");
    end
    $finish;
  end
endmodule

[tukey_window_2d_weight.f]
rtl/core/twd_pkg.sv
rtl/core/twd_lane.sv
rtl/core/tukey_window_2d_weight.sv
tb/twd_weight_checker.sv
tb/tb_tukey_window_2d_weight.sv
